>>> sv/glzw_pkg.sv
package glzw_pkg;

    localparam int CODE_W = 12;
    localparam int BYTE_W = 8;
    localparam int SIZE_W = 4;
    localparam int STAT_W = 3;
    localparam int WID_W  = 4;
    localparam int CLR_W  = 16;

    localparam logic ACT_RESET = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    localparam logic [STAT_W-1:0] ST_BYTE       = 3'd0;
    localparam logic [STAT_W-1:0] ST_RESET_DONE = 3'd1;
    localparam logic [STAT_W-1:0] ST_SIZE_ERR   = 3'd2;
    localparam logic [STAT_W-1:0] ST_END        = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOBYTE     = 3'd4;
    localparam logic [STAT_W-1:0] ST_CORRUPT    = 3'd5;

    typedef struct packed {
        logic              action;
        logic [CODE_W-1:0] code;
        logic [SIZE_W-1:0] initial_size;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic [STAT_W-1:0] status;
        logic              code_taken;
        logic [WID_W-1:0]  code_width;
    } t_out_item;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_DIRECT,
        CMD_POP_RD,
        CMD_POP_OUT,
        CMD_WALK_START,
        CMD_WALK_STEP,
        CMD_FINISH
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic out_free;
        logic direct;
        logic pop;
        logic walk_go;
        logic step_more;
    } t_dp_stat;

endpackage

>>> sv/gif_lzw_code_decoder_unit.sv
// GIF-style variable-width LZW code decoder. Each request either resets the decoder with a
// new minimum code size or offers one unpacked code; every request yields exactly one result
// carrying a byte or a status, a code-taken flag and the code width the bit unpacker must use
// next. Requests are registered on entry, so a new one is accepted while the previous result
// still waits downstream. A reset, clear, end or first code after a clear is answered straight
// from the registered request; a byte popped from the expansion stack waits for the registered
// stack read; a code that is expanded first walks its prefix links, one dictionary read per link
// through the single table port. The dictionary and the stack are plain memories with no
// clearing pass after reset: a chain that reaches an entry never written since the last reset
// request or clear code gives undefined bytes.
module gif_lzw_code_decoder_unit #(
    parameter int MAX_BITS    = 12,
    parameter int STACK_DEPTH = 8192
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  glzw_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output glzw_pkg::t_out_item o_out_data
);

    glzw_pkg::t_cmd     cmd;
    glzw_pkg::t_dp_stat stat;

    glzw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    glzw_datapath #(
        .MAX_BITS    (MAX_BITS),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cmd       (cmd),
        .o_stat      (stat)
    );

endmodule

>>> sv/glzw_ctrl.sv
module glzw_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  glzw_pkg::t_dp_stat i_stat,
    output glzw_pkg::t_cmd     o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_POP  = 4'b0010,
        S_WALK = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = glzw_pkg::CMD_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_stat.in_valid) begin
                    if (i_stat.direct) begin
                        if (i_stat.out_free) begin
                            o_cmd = glzw_pkg::CMD_DIRECT;
                        end
                    end else if (i_stat.pop) begin
                        o_cmd   = glzw_pkg::CMD_POP_RD;
                        n_state = S_POP;
                    end else begin
                        o_cmd   = glzw_pkg::CMD_WALK_START;
                        n_state = i_stat.walk_go ? S_WALK : S_FIN;
                    end
                end
            end
            S_POP: begin
                if (i_stat.out_free) begin
                    o_cmd   = glzw_pkg::CMD_POP_OUT;
                    n_state = S_IDLE;
                end
            end
            S_WALK: begin
                o_cmd   = glzw_pkg::CMD_WALK_STEP;
                n_state = i_stat.step_more ? S_WALK : S_FIN;
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd   = glzw_pkg::CMD_FINISH;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> sv/glzw_datapath.sv
module glzw_datapath #(
    parameter int MAX_BITS    = 12,
    parameter int STACK_DEPTH = 8192
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  glzw_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output glzw_pkg::t_out_item o_out_data,
    input  glzw_pkg::t_cmd      i_cmd,
    output glzw_pkg::t_dp_stat  o_stat
);

    localparam int CODE_W    = glzw_pkg::CODE_W;
    localparam int BYTE_W    = glzw_pkg::BYTE_W;
    localparam int WID_W     = glzw_pkg::WID_W;
    localparam int CLR_W     = glzw_pkg::CLR_W;
    localparam int SIZE_W    = glzw_pkg::SIZE_W;
    localparam int TBL_DEPTH = 1 << MAX_BITS;
    localparam int TBL_AW    = MAX_BITS;
    localparam int NF_W      = MAX_BITS + 1;
    localparam int WL_W      = MAX_BITS + 2;
    localparam int SA_W      = $clog2(STACK_DEPTH);
    localparam int SF_W      = SA_W + 1;
    localparam int ENT_W     = CODE_W + BYTE_W;

    logic                r_in_valid;
    logic                n_in_valid;
    glzw_pkg::t_in_item  r_in;
    logic                r_out_valid;
    logic                n_out_valid;
    glzw_pkg::t_out_item r_out;
    glzw_pkg::t_out_item n_out;
    logic                out_load;

    logic [SF_W-1:0]     r_fill;
    logic [SF_W-1:0]     n_fill;
    logic [WID_W-1:0]    r_width;
    logic [WID_W-1:0]    n_width;
    logic [SIZE_W-1:0]   r_root;
    logic [SIZE_W-1:0]   n_root;
    logic [NF_W-1:0]     r_nf;
    logic [NF_W-1:0]     n_nf;
    logic [WL_W-1:0]     r_limit;
    logic [WL_W-1:0]     n_limit;
    logic [BYTE_W-1:0]   r_first;
    logic [BYTE_W-1:0]   n_first;
    logic [CODE_W-1:0]   r_prior;
    logic [CODE_W-1:0]   n_prior;
    logic                r_fresh;
    logic                n_fresh;
    logic [CODE_W-1:0]   r_c;
    logic [CODE_W-1:0]   n_c;
    logic                r_bad;
    logic                n_bad;

    logic [ENT_W-1:0]    r_tbl_mem [TBL_DEPTH];
    logic [ENT_W-1:0]    r_tbl_q;
    logic                r_tbl_inr;
    logic                tbl_re;
    logic [CODE_W-1:0]   tbl_rcode;
    logic                tbl_we;

    logic [BYTE_W-1:0]   r_stk_mem [STACK_DEPTH];
    logic [BYTE_W-1:0]   r_stk_q;
    logic                stk_we;
    logic [BYTE_W-1:0]   stk_wd;
    logic                stk_re;
    logic [SF_W-1:0]     fill_m1;

    logic [CLR_W-1:0]    clr;
    logic                is_clr;
    logic                is_end;
    logic                stack_full;
    logic                kwk;
    logic [CODE_W-1:0]   start_c;
    logic                start_bad;
    logic                walk_go;
    logic [CODE_W-1:0]   link_pre;
    logic [BYTE_W-1:0]   link_suf;
    logic                step_more;
    logic                direct;
    logic [NF_W-1:0]     nf_inc;

    logic                do_restart;
    logic [SIZE_W-1:0]   rs_root;
    logic [CLR_W-1:0]    rs_clr;

    assign clr        = CLR_W'(1) << r_root;
    assign is_clr     = 32'(r_in.code) == 32'(clr);
    assign is_end     = 32'(r_in.code) == 32'(clr) + 32'd1;
    assign stack_full = 32'(r_fill) >= 32'(STACK_DEPTH);
    assign kwk        = 32'(r_in.code) >= 32'(r_nf);
    assign start_c    = kwk ? r_prior : r_in.code;
    assign start_bad  = kwk && stack_full;
    assign walk_go    = !start_bad && (32'(start_c) >= 32'(clr));
    assign link_pre   = r_tbl_inr ? r_tbl_q[ENT_W-1:BYTE_W] : '0;
    assign link_suf   = r_tbl_inr ? r_tbl_q[BYTE_W-1:0] : '0;
    assign step_more  = !stack_full && (link_pre != r_c) && (32'(link_pre) >= 32'(clr));
    assign direct     = (r_in.action == glzw_pkg::ACT_RESET)
                     || ((r_fill == '0) && (r_fresh || is_clr || is_end));
    assign fill_m1    = r_fill - SF_W'(1);
    assign nf_inc     = r_nf + NF_W'(1);

    assign o_stat.in_valid  = r_in_valid;
    assign o_stat.out_free  = !r_out_valid || !i_out_stall;
    assign o_stat.direct    = direct;
    assign o_stat.pop       = r_fill != '0;
    assign o_stat.walk_go   = walk_go;
    assign o_stat.step_more = step_more;

    assign o_in_stall  = r_in_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_in_valid  = r_in_valid;
        n_out_valid = r_out_valid & i_out_stall;
        out_load    = 1'b0;
        n_out       = '0;
        n_fill      = r_fill;
        n_width     = r_width;
        n_root      = r_root;
        n_nf        = r_nf;
        n_limit     = r_limit;
        n_first     = r_first;
        n_prior     = r_prior;
        n_fresh     = r_fresh;
        n_c         = r_c;
        n_bad       = r_bad;
        do_restart  = 1'b0;
        rs_root     = r_root;
        rs_clr      = clr;
        tbl_re      = 1'b0;
        tbl_rcode   = start_c;
        tbl_we      = 1'b0;
        stk_we      = 1'b0;
        stk_wd      = r_first;
        stk_re      = 1'b0;

        if (i_in_valid && !r_in_valid) begin
            n_in_valid = 1'b1;
        end

        unique case (i_cmd)
            glzw_pkg::CMD_DIRECT: begin
                n_in_valid = 1'b0;
                out_load   = 1'b1;
                if (r_in.action == glzw_pkg::ACT_RESET) begin
                    n_out.code_taken = 1'b0;
                    if (32'(r_in.initial_size) > 32'(MAX_BITS)) begin
                        n_out.status = glzw_pkg::ST_SIZE_ERR;
                    end else begin
                        n_root       = r_in.initial_size;
                        rs_root      = r_in.initial_size;
                        do_restart   = 1'b1;
                        n_out.status = glzw_pkg::ST_RESET_DONE;
                    end
                end else begin
                    n_out.code_taken = 1'b1;
                    if (r_fresh) begin
                        if (is_clr) begin
                            n_out.status = glzw_pkg::ST_NOBYTE;
                        end else begin
                            n_fresh         = 1'b0;
                            n_first         = r_in.code[BYTE_W-1:0];
                            n_prior         = r_in.code;
                            n_out.data_byte = r_in.code[BYTE_W-1:0];
                            n_out.status    = glzw_pkg::ST_BYTE;
                        end
                    end else if (is_clr) begin
                        do_restart   = 1'b1;
                        n_out.status = glzw_pkg::ST_NOBYTE;
                    end else begin
                        n_out.status = glzw_pkg::ST_END;
                    end
                end
            end
            glzw_pkg::CMD_POP_RD: begin
                stk_re = 1'b1;
            end
            glzw_pkg::CMD_POP_OUT: begin
                n_in_valid       = 1'b0;
                out_load         = 1'b1;
                n_fill           = fill_m1;
                n_out.data_byte  = r_stk_q;
                n_out.status     = glzw_pkg::ST_BYTE;
                n_out.code_taken = 1'b0;
            end
            glzw_pkg::CMD_WALK_START: begin
                n_bad = start_bad;
                n_c   = start_c;
                if (kwk && !stack_full) begin
                    stk_we = 1'b1;
                    stk_wd = r_first;
                    n_fill = r_fill + SF_W'(1);
                end
                if (walk_go) begin
                    tbl_re    = 1'b1;
                    tbl_rcode = start_c;
                end
            end
            glzw_pkg::CMD_WALK_STEP: begin
                if (stack_full) begin
                    n_bad = 1'b1;
                end else begin
                    stk_we = 1'b1;
                    stk_wd = link_suf;
                    n_fill = r_fill + SF_W'(1);
                end
                if (link_pre == r_c) begin
                    n_bad = 1'b1;
                end
                n_c = link_pre;
                if (step_more) begin
                    tbl_re    = 1'b1;
                    tbl_rcode = link_pre;
                end
            end
            glzw_pkg::CMD_FINISH: begin
                n_in_valid       = 1'b0;
                out_load         = 1'b1;
                n_out.code_taken = 1'b1;
                if (r_bad || stack_full) begin
                    n_fill       = '0;
                    n_out.status = glzw_pkg::ST_CORRUPT;
                end else begin
                    n_first = r_c[BYTE_W-1:0];
                    if (32'(r_nf) < 32'(TBL_DEPTH)) begin
                        tbl_we = 1'b1;
                        n_nf   = nf_inc;
                        if ((32'(nf_inc) >= 32'(r_limit))
                                && (32'(r_limit) < 32'(TBL_DEPTH))) begin
                            n_limit = r_limit << 1;
                            n_width = r_width + WID_W'(1);
                        end
                    end
                    n_prior         = r_in.code;
                    n_out.data_byte = r_c[BYTE_W-1:0];
                    n_out.status    = glzw_pkg::ST_BYTE;
                end
            end
            default: begin
            end
        endcase

        if (do_restart) begin
            rs_clr  = CLR_W'(1) << rs_root;
            n_width = rs_root + WID_W'(1);
            n_limit = WL_W'({rs_clr, 1'b0});
            n_nf    = NF_W'(32'(rs_clr) + 32'd2);
            n_fill  = '0;
            n_fresh = 1'b1;
        end

        if (out_load) begin
            n_out_valid = 1'b1;
        end
        n_out.code_width = n_width;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_fill      <= '0;
            r_width     <= WID_W'(1);
            r_root      <= '0;
            r_nf        <= '0;
            r_limit     <= '0;
            r_first     <= '0;
            r_prior     <= '0;
            r_fresh     <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            r_fill      <= n_fill;
            r_width     <= n_width;
            r_root      <= n_root;
            r_nf        <= n_nf;
            r_limit     <= n_limit;
            r_first     <= n_first;
            r_prior     <= n_prior;
            r_fresh     <= n_fresh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !r_in_valid) begin
            r_in <= i_in_data;
        end
        if (out_load) begin
            r_out <= n_out;
        end
        r_c   <= n_c;
        r_bad <= n_bad;
    end

    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_tbl_mem[r_nf[TBL_AW-1:0]] <= {r_prior, r_c[BYTE_W-1:0]};
        end
        if (tbl_re) begin
            r_tbl_q   <= r_tbl_mem[TBL_AW'(tbl_rcode)];
            r_tbl_inr <= (32'(tbl_rcode) >> MAX_BITS) == 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stk_mem[r_fill[SA_W-1:0]] <= stk_wd;
        end
        if (stk_re) begin
            r_stk_q <= r_stk_mem[fill_m1[SA_W-1:0]];
        end
    end

endmodule

>>> sv/glzw_checker.sv
module glzw_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input glzw_pkg::t_out_item o_out_data
);

    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status != glzw_pkg::ST_BYTE)
        |-> o_out_data.data_byte == '0)
        else $error("non-byte result carries a data byte");

    a_reset_not_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ((o_out_data.status == glzw_pkg::ST_RESET_DONE)
                     || (o_out_data.status == glzw_pkg::ST_SIZE_ERR))
        |-> !o_out_data.code_taken)
        else $error("reset result marks code as taken");

    a_code_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ((o_out_data.status == glzw_pkg::ST_END)
                     || (o_out_data.status == glzw_pkg::ST_NOBYTE)
                     || (o_out_data.status == glzw_pkg::ST_CORRUPT))
        |-> o_out_data.code_taken)
        else $error("code-consuming result does not mark code as taken");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not empty after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed or dropped");

endmodule

bind gif_lzw_code_decoder_unit glzw_checker u_glzw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
